// ----- design/rtt_pkg.sv -----
// Shared types and constants of the repeating timer table.
package rtt_pkg;

    // Input command codes (carried on the slave tuser bit)
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Field widths fixed by the stream format
    localparam int IN_TIME_W  = 32;
    localparam int REP_W      = 17;
    localparam int HND_W      = 16;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    // Repeat count that never runs out
    localparam logic [REP_W-1:0] REP_FOREVER = '1;

    // Result kinds (carried on the master tuser bits)
    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_FIRED   = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_IDLE    = 3'd4
    } t_kind;

    // Entry memory control
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ----- design/repeating_timer_table.sv -----
// Top level of the repeating timer table: sequencer, slot flags and output register.
//
//  channel | port group     | word contents
//  --------+----------------+---------------------------------------------------
//  input   | s_axis_*       | tuser: command; tdata: now, period, repeats, handle
//  output  | m_axis_*       | tuser: kind; tdata: slot, owner; tlast: last
//
// Every command word is accepted in idle; the input is ready only between commands.
// After that, an add walks the slot flags one slot a cycle from slot 0.
// A tick reads each used slot from memory, then compares and updates it through
// the shared unit; free slots are skipped, an expiry ends the scan, and a closing
// state sends the final word. Reset clears the state, slot flags and valid flags,
// not the entry memory. A stalled output holds the sequencer in place where it
// has a word to push, until the output register frees.
module repeating_timer_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] now, [63:32] period, [80:64] repeats, [96:81] handle, rest zero
    input  logic [rtt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] slot, [19:4] owner, rest zero
    output logic [rtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [2:0] kind
    output logic [rtt_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REP_W  = rtt_pkg::REP_W;
    localparam int HND_W  = rtt_pkg::HND_W;
    localparam int MEM_W  = 2 * TIME_BITS + REP_W + HND_W;
    localparam int IN_TW  = rtt_pkg::IN_TIME_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_TSEL,
        S_TEVAL,
        S_TEND
    } t_state;

    // Latched command
    logic [TIME_BITS-1:0]  r_now;
    logic [TIME_BITS-1:0]  r_period;
    logic [REP_W-1:0]      r_rep;
    logic [HND_W-1:0]      r_hnd;

    // Sequencer
    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic [SLOTS-1:0]      r_used, n_used;

    // Held result of a tick, sent once the next one (or the end) is known
    logic                  r_pend_valid, n_pend_valid;
    rtt_pkg::t_kind        r_pend_kind, n_pend_kind;
    logic [IW-1:0]         r_pend_slot, n_pend_slot;
    logic [HND_W-1:0]      r_pend_owner, n_pend_owner;

    // Output register
    logic                  r_out_valid, n_out_valid;
    rtt_pkg::t_kind        r_out_kind, n_out_kind;
    logic [IW-1:0]         r_out_slot, n_out_slot;
    logic [HND_W-1:0]      r_out_owner, n_out_owner;
    logic                  r_out_last, n_out_last;

    logic                  w_in_accept;
    logic                  w_can_push;
    logic [IN_TW+TIME_BITS-1:0] w_now_ext;
    logic [IN_TW+TIME_BITS-1:0] w_per_ext;
    logic [IW+rtt_pkg::SLOT_W-1:0] w_slot_ext;

    // Memory and shared unit
    rtt_pkg::t_mem_ctl     w_mem_ctl;
    logic [MEM_W-1:0]      w_mem_wdata;
    logic [MEM_W-1:0]      w_mem_rdata;
    logic [TIME_BITS-1:0]  w_rd_due;
    logic [TIME_BITS-1:0]  w_rd_period;
    logic [REP_W-1:0]      w_rd_rep;
    logic [HND_W-1:0]      w_rd_hnd;
    logic [TIME_BITS-1:0]  w_alu_period;
    logic [TIME_BITS-1:0]  w_alu_sum;
    logic                  w_alu_due;
    logic [REP_W-1:0]      w_alu_rep_next;
    logic                  w_alu_rep_zero;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_can_push  = !r_out_valid || m_axis_tready;

    // Fit the 32-bit time fields to the internal time width
    assign w_now_ext = {{TIME_BITS{1'b0}}, s_axis_tdata[31:0]};
    assign w_per_ext = {{TIME_BITS{1'b0}}, s_axis_tdata[63:32]};

    // Capture the command word
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_now    <= w_now_ext[TIME_BITS-1:0];
            r_period <= w_per_ext[TIME_BITS-1:0];
            r_rep    <= s_axis_tdata[80:64];
            r_hnd    <= s_axis_tdata[96:81];
        end
    end

    // Split the read entry
    assign {w_rd_due, w_rd_period, w_rd_rep, w_rd_hnd} = w_mem_rdata;

    assign w_alu_period = (r_state == S_ADD) ? r_period : w_rd_period;

    rtt_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_now      (r_now),
        .i_period   (w_alu_period),
        .i_due      (w_rd_due),
        .i_rep      (w_rd_rep),
        .o_sum      (w_alu_sum),
        .o_is_due   (w_alu_due),
        .o_rep_next (w_alu_rep_next),
        .o_rep_zero (w_alu_rep_zero)
    );

    rtt_mem #(
        .DEPTH (SLOTS),
        .WIDTH (MEM_W),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (r_idx),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // New entry on add, rescheduled entry on fire
    assign w_mem_wdata = (r_state == S_ADD)
                       ? {w_alu_sum, r_period, r_rep, r_hnd}
                       : {w_alu_sum, w_rd_period, w_alu_rep_next, w_rd_hnd};

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_slot  = r_pend_slot;
        n_pend_owner = r_pend_owner;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_owner  = r_out_owner;
        n_out_last   = r_out_last;
        w_mem_ctl    = '0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_idx   = '0;
                    n_state = (s_axis_tuser == rtt_pkg::CMD_ADD) ? S_ADD : S_TSEL;
                end
            end

            // Look for the lowest free slot
            S_ADD: begin
                if (!r_used[r_idx]) begin
                    if (w_can_push) begin
                        w_mem_ctl.wr_en = 1'b1;
                        n_used[r_idx]   = 1'b1;
                        n_out_valid     = 1'b1;
                        n_out_kind      = rtt_pkg::KIND_ADDED;
                        n_out_slot      = r_idx;
                        n_out_owner     = r_hnd;
                        n_out_last      = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (w_can_push) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = rtt_pkg::KIND_FULL;
                        n_out_slot  = '0;
                        n_out_owner = r_hnd;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            // Skip free slots, read used ones
            S_TSEL: begin
                if (r_used[r_idx]) begin
                    w_mem_ctl.rd_en = 1'b1;
                    n_state         = S_TEVAL;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_TEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            // Test the slot; fire or expire it if due
            S_TEVAL: begin
                if (!w_alu_due) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = S_TEND;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_TSEL;
                    end
                end else if (!r_pend_valid || w_can_push) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_slot  = r_pend_slot;
                        n_out_owner = r_pend_owner;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_slot  = r_idx;
                    n_pend_owner = w_rd_hnd;
                    if (!w_alu_rep_zero) begin
                        w_mem_ctl.wr_en = 1'b1;
                        n_pend_kind     = rtt_pkg::KIND_FIRED;
                        if (r_idx == LAST_IDX) begin
                            n_state = S_TEND;
                        end else begin
                            n_idx   = r_idx + IW'(1);
                            n_state = S_TSEL;
                        end
                    end else begin
                        n_used[r_idx] = 1'b0;
                        n_pend_kind   = rtt_pkg::KIND_EXPIRED;
                        n_state       = S_TEND;
                    end
                end
            end

            // Send the final word of the tick
            S_TEND: begin
                if (w_can_push) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_kind  = r_pend_kind;
                        n_out_slot  = r_pend_slot;
                        n_out_owner = r_pend_owner;
                    end else begin
                        n_out_kind  = rtt_pkg::KIND_IDLE;
                        n_out_slot  = '0;
                        n_out_owner = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_pend_kind  <= n_pend_kind;
        r_pend_slot  <= n_pend_slot;
        r_pend_owner <= n_pend_owner;
        r_out_kind   <= n_out_kind;
        r_out_slot   <= n_out_slot;
        r_out_owner  <= n_out_owner;
        r_out_last   <= n_out_last;
    end

    // Drive the output word
    assign w_slot_ext    = {{rtt_pkg::SLOT_W{1'b0}}, r_out_slot};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, r_out_owner, w_slot_ext[rtt_pkg::SLOT_W-1:0]};

    // Rescheduling writes only touch slots that are in use
    a_fire_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_ctl.wr_en && r_state == S_TEVAL) |-> r_used[r_idx])
        else $error("timer entry rewritten in a free slot");

    // A successful add marks its slot used
    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_ctl.wr_en && r_state == S_ADD) |=> r_used[$past(r_idx)])
        else $error("added slot not marked used");

    // No held result survives the end of a command
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held result left over between commands");

    // Finishing a command always leaves a final word in the output register
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |=> (r_out_valid && r_out_last))
        else $error("command finished without a final word");

endmodule

// ----- design/rtt_mem.sv -----
// Single-port timer entry memory with registered read data.
module rtt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 97,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  rtt_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]       i_addr,
    input  logic [WIDTH-1:0]    i_wdata,
    output logic [WIDTH-1:0]    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry; read data holds when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rtt_alu.sv -----
// Shared time adder, due compare and repeat count decrement.
module rtt_alu #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0]      i_now,
    input  logic [TIME_BITS-1:0]      i_period,
    input  logic [TIME_BITS-1:0]      i_due,
    input  logic [rtt_pkg::REP_W-1:0] i_rep,
    output logic [TIME_BITS-1:0]      o_sum,
    output logic                      o_is_due,
    output logic [rtt_pkg::REP_W-1:0] o_rep_next,
    output logic                      o_rep_zero
);

    logic [TIME_BITS-1:0] w_diff;

    // Next due time, wrapping
    assign o_sum = i_now + i_period;

    // Due when now is at or past the due time within half the time range
    assign w_diff   = i_now - i_due;
    assign o_is_due = ~w_diff[TIME_BITS-1];

    // Count down unless repeating forever
    assign o_rep_next = (i_rep == rtt_pkg::REP_FOREVER) ? i_rep
                                                         : i_rep - rtt_pkg::REP_W'(1);
    assign o_rep_zero = (i_rep == '0);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking stream testbench for the repeating timer table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 32;
    localparam int IDLE_PCT   = 35;
    localparam int RAND_ITEMS = 255;

    // One command word as the sender sees it
    typedef struct {
        logic                          cmd;
        logic [rtt_pkg::IN_TIME_W-1:0] now;
        logic [rtt_pkg::IN_TIME_W-1:0] period;
        logic [rtt_pkg::REP_W-1:0]     repeats;
        logic [rtt_pkg::HND_W-1:0]     handle;
    } t_timer_cmd;

    // One result word as the table should report it
    typedef struct {
        rtt_pkg::t_kind             kind;
        logic [rtt_pkg::SLOT_W-1:0] slot;
        logic [rtt_pkg::HND_W-1:0]  owner;
        logic                       last;
    } t_timer_event;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [rtt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rtt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [rtt_pkg::KIND_W-1:0]     m_axis_tuser;
    logic                           m_axis_tlast;

    t_timer_cmd   cmd_q[$];
    t_timer_event timer_events_q[$];
    t_timer_cmd   held_cmd;
    int           words_sent = 0;
    int           fail_cnt = 0;
    logic         calm;

    // Shadow copy of the timer table
    logic                          slot_busy [SLOTS];
    logic [rtt_pkg::IN_TIME_W-1:0] slot_due  [SLOTS];
    logic [rtt_pkg::IN_TIME_W-1:0] slot_every[SLOTS];
    logic [rtt_pkg::REP_W-1:0]     slot_left [SLOTS];
    logic [rtt_pkg::HND_W-1:0]     slot_owner[SLOTS];

    repeating_timer_table #(
        .SLOTS    (SLOTS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // No idling on either side through a stretch in the middle of the run
    assign calm = (words_sent >= 100) && (words_sent < 160);

    // Apply one accepted command to the shadow table and queue its results
    task automatic step_table(input t_timer_cmd c);
        t_timer_event ev;
        t_timer_event prev;
        logic         have_prev;
        logic         stop;
        logic [rtt_pkg::IN_TIME_W-1:0] lag;
        have_prev = 1'b0;
        stop      = 1'b0;
        if (c.cmd == rtt_pkg::CMD_ADD) begin
            ev = '{kind: rtt_pkg::KIND_FULL, slot: '0, owner: c.handle, last: 1'b1};
            for (int i = 0; i < SLOTS && !stop; i++) begin
                if (!slot_busy[i]) begin
                    slot_busy[i]  = 1'b1;
                    slot_due[i]   = c.now + c.period;
                    slot_every[i] = c.period;
                    slot_left[i]  = c.repeats;
                    slot_owner[i] = c.handle;
                    ev.kind = rtt_pkg::KIND_ADDED;
                    ev.slot = rtt_pkg::SLOT_W'(i);
                    stop    = 1'b1;
                end
            end
            timer_events_q.push_back(ev);
        end else begin
            for (int i = 0; i < SLOTS && !stop; i++) begin
                lag = c.now - slot_due[i];
                // Wrap-aware due test: due when now is at most half a range ahead
                if (slot_busy[i] && !lag[rtt_pkg::IN_TIME_W-1]) begin
                    ev.slot  = rtt_pkg::SLOT_W'(i);
                    ev.owner = slot_owner[i];
                    ev.last  = 1'b0;
                    if (slot_left[i] != '0) begin
                        slot_due[i] = c.now + slot_every[i];
                        if (slot_left[i] != rtt_pkg::REP_FOREVER)
                            slot_left[i] = slot_left[i] - 1'b1;
                        ev.kind = rtt_pkg::KIND_FIRED;
                    end else begin
                        // Free the first spent timer and end the scan there
                        slot_busy[i] = 1'b0;
                        ev.kind      = rtt_pkg::KIND_EXPIRED;
                        stop         = 1'b1;
                    end
                    if (have_prev)
                        timer_events_q.push_back(prev);
                    prev      = ev;
                    have_prev = 1'b1;
                end
            end
            if (!have_prev)
                prev = '{kind: rtt_pkg::KIND_IDLE, slot: '0, owner: '0, last: 1'b0};
            prev.last = 1'b1;
            timer_events_q.push_back(prev);
        end
    endtask

    task automatic queue_cmd(input logic cmd, input logic [31:0] now,
                             input logic [31:0] period, input logic [16:0] repeats,
                             input logic [15:0] handle);
        t_timer_cmd c;
        c.cmd     = cmd;
        c.now     = now;
        c.period  = period;
        c.repeats = repeats;
        c.handle  = handle;
        cmd_q.push_back(c);
    endtask

    // Send command words; predict each one as it is accepted
    always @(posedge i_clk) begin : cmd_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_table(held_cmd);
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    held_cmd = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= held_cmd.cmd;
                    s_axis_tdata  <= {7'd0, held_cmd.handle, held_cmd.repeats,
                                      held_cmd.period, held_cmd.now};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each result word against the oldest expectation; stall at random
    always @(posedge i_clk) begin : result_monitor
        t_timer_event exp_ev;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (timer_events_q.size() == 0) begin
                $error("unexpected result: kind %0d slot %0d owner %0d last %0d",
                       m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast);
                fail_cnt++;
            end else begin
                exp_ev = timer_events_q.pop_front();
                if (m_axis_tuser !== exp_ev.kind) begin
                    $error("kind: expected %0d, got %0d", exp_ev.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata[3:0] !== exp_ev.slot) begin
                    $error("slot: expected %0d, got %0d", exp_ev.slot, m_axis_tdata[3:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[19:4] !== exp_ev.owner) begin
                    $error("owner: expected %0d, got %0d", exp_ev.owner,
                           m_axis_tdata[19:4]);
                    fail_cnt++;
                end
                if (m_axis_tdata[rtt_pkg::OUT_DATA_W-1:20] !== '0) begin
                    $error("tdata pad: expected 0, got %0h",
                           m_axis_tdata[rtt_pkg::OUT_DATA_W-1:20]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== exp_ev.last) begin
                    $error("last: expected %0d, got %0d", exp_ev.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin : stimulus
        logic [31:0] gen_now;
        logic [31:0] period;
        logic [16:0] repeats;
        int          r;
        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;

        // Directed: empty tick, field extremes, every count style, expiry, full table
        queue_cmd(rtt_pkg::CMD_TICK, 32'd0, 32'd0, 17'd0, 16'd0);
        queue_cmd(rtt_pkg::CMD_ADD, 32'd0, 32'd0, 17'd0, 16'h0000);
        queue_cmd(rtt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rtt_pkg::REP_FOREVER,
                  16'hFFFF);
        queue_cmd(rtt_pkg::CMD_ADD, 32'd10, 32'd5, 17'd2, 16'h1234);
        queue_cmd(rtt_pkg::CMD_ADD, 32'd10, 32'd3, 17'h1FFFE, 16'hABCD);
        queue_cmd(rtt_pkg::CMD_ADD, 32'd10, 32'd1, 17'h0FFFF, 16'h5555);
        queue_cmd(rtt_pkg::CMD_TICK, 32'd20, 32'hFFFF_FFFF, 17'h1FFFF, 16'hFFFF);
        queue_cmd(rtt_pkg::CMD_TICK, 32'd20, 32'd0, 17'd0, 16'd0);
        queue_cmd(rtt_pkg::CMD_TICK, 32'd30, 32'd0, 17'd0, 16'd0);
        queue_cmd(rtt_pkg::CMD_TICK, 32'd40, 32'd0, 17'd0, 16'd0);
        for (int i = 0; i < 13; i++)
            queue_cmd(rtt_pkg::CMD_ADD, 32'd40, 32'd7 + 32'(i), 17'd1,
                      16'h0100 + 16'(i));
        queue_cmd(rtt_pkg::CMD_TICK, 32'h8000_0010, 32'd0, 17'd0, 16'd0);
        queue_cmd(rtt_pkg::CMD_TICK, 32'hFFFF_FFF0, 32'd0, 17'd0, 16'd0);

        // Random: mostly add/tick sequences on an advancing clock, some noise
        gen_now = $urandom();
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                queue_cmd(1'($urandom()), $urandom(), $urandom(), 17'($urandom()),
                          16'($urandom()));
            end else if (r < 50) begin
                r = $urandom_range(99);
                if (r < 10)      period = 32'd0;
                else if (r < 15) period = $urandom();
                else             period = $urandom_range(1, 12);
                r = $urandom_range(99);
                if (r < 60)      repeats = 17'($urandom_range(0, 3));
                else if (r < 75) repeats = rtt_pkg::REP_FOREVER;
                else if (r < 85) repeats = 17'h10000 | 17'($urandom_range(0, 16'hFFFF));
                else if (r < 90) repeats = 17'($urandom_range(4, 16'hFFFF));
                else             repeats = 17'($urandom_range(4, 8));
                queue_cmd(rtt_pkg::CMD_ADD,
                          ($urandom_range(99) < 85) ? gen_now : $urandom(),
                          period, repeats, 16'($urandom()));
            end else begin
                if ($urandom_range(99) < 6) gen_now = gen_now + $urandom();
                else                        gen_now = gen_now + $urandom_range(0, 9);
                queue_cmd(rtt_pkg::CMD_TICK, gen_now, $urandom(), 17'($urandom()),
                          16'($urandom()));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words sent, all results seen, then a quiet tail
        @(posedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || timer_events_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
        if (timer_events_q.size() != 0) begin
            $error("results never arrived: %0d", timer_events_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
